/* hw/rtl/bitmap_block_inode_allocator_top_defines.svh */
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_INODE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_INODE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BBIA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBIA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bbia_pkg.sv */
// ----------------------------------------------------------------------------
// bbia_pkg
// Types, codes and helpers for the block and inode free-map allocator.
// ----------------------------------------------------------------------------
package bbia_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 131072;
    localparam int unsigned MAX_INODES_DEF = 8192;
    localparam int unsigned MAX_RUN_DEF    = 16;

    localparam logic [17:0] BLOCK_COUNT_RST     = 18'd102400;
    localparam logic [13:0] INODE_COUNT_RST     = 14'd8192;
    localparam logic [17:0] RESERVED_BLOCKS_RST = 18'd2063;

    localparam logic [1:0] CFG_BLOCK_COUNT     = 2'd0;
    localparam logic [1:0] CFG_INODE_COUNT     = 2'd1;
    localparam logic [1:0] CFG_RESERVED_BLOCKS = 2'd2;

    localparam logic [1:0] CMD_ALLOC_BLOCK = 2'd0;
    localparam logic [1:0] CMD_FREE_BLOCK  = 2'd1;
    localparam logic [1:0] CMD_ALLOC_INODE = 2'd2;
    localparam logic [1:0] CMD_FREE_INODE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  count;
        logic [16:0] index;
    } in_t;

    typedef struct packed {
        logic [16:0] result_index;
        logic [1:0]  status;
        logic        last;
    } out_t;

    typedef struct packed {
        logic fire;
        out_t res;
    } emit_t;

    typedef struct packed {
        logic       any;
        logic [5:0] first;
        logic [6:0] pop;
    } scan_info_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BRD1,
        S_BEV1,
        S_BRD2,
        S_BEV2,
        S_BPICK,
        S_FBRD,
        S_FBWR,
        S_IRD,
        S_IEV,
        S_FIRD,
        S_FIWR,
        S_EMIT
    } state_t;

    // lowest set bit of a word
    function automatic logic [5:0] first_set(input logic [63:0] v);
        logic [5:0] r;
        r = 6'd0;
        for (int j = 63; j >= 0; j--)
        begin
            if (v[j])
            begin
                r = 6'(j);
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/bbia_scan.sv */
// ----------------------------------------------------------------------------
// bbia_scan
// Free-bit mask of one map word inside a [lo, hi) window, with count and
// lowest free position.
// ----------------------------------------------------------------------------
module bbia_scan #(
    parameter int unsigned W = 18
) (
    input  logic [63:0]           word,
    input  logic [W-1:0]          base,
    input  logic [W-1:0]          lo,
    input  logic [W-1:0]          hi,
    output logic [63:0]           free,
    output bbia_pkg::scan_info_t  info
);

    logic [W-1:0] pos [64];

    always_comb
    begin
        for (int j = 0; j < 64; j++)
        begin
            pos[j]  = base + W'(j);
            free[j] = !word[j] && (pos[j] >= lo) && (pos[j] < hi);
        end
    end

    assign info.any   = |free;
    assign info.first = bbia_pkg::first_set(free);
    assign info.pop   = 7'($countones(free));

endmodule

/* hw/rtl/bbia_ctrl.sv */
// ----------------------------------------------------------------------------
// bbia_ctrl
// Sequencer and free-map memories: word scans, read-modify-write of map words
// and issue of results.
// ----------------------------------------------------------------------------
`include "bitmap_block_inode_allocator_top_defines.svh"

module bbia_ctrl #(
    parameter int unsigned MAX_BLOCKS = bbia_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned MAX_INODES = bbia_pkg::MAX_INODES_DEF,
    parameter int unsigned MAX_RUN    = bbia_pkg::MAX_RUN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [17:0]       block_count,
    input  logic [13:0]       inode_count,
    input  logic [17:0]       reserved_blocks,
    input  logic              in_valid,
    input  bbia_pkg::in_t     in_data,
    output logic              in_ready,
    input  logic              slot_free,
    output bbia_pkg::emit_t   emit
);

    localparam int unsigned BWD  = (MAX_BLOCKS + 63) / 64;
    localparam int unsigned IWD  = (MAX_INODES + 63) / 64;
    localparam int unsigned BAW  = (BWD > 1) ? $clog2(BWD) : 1;
    localparam int unsigned IAW  = (IWD > 1) ? $clog2(IWD) : 1;
    localparam int unsigned BCW  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned CBW  = (BCW > 18) ? BCW : 18;
    localparam int unsigned ICW  = $clog2(MAX_INODES + 1);
    localparam int unsigned CIW  = (ICW > 17) ? ICW : 17;
    localparam int unsigned GW   = $clog2(MAX_RUN + 1);
    localparam int unsigned SW   = ((GW > 7) ? GW : 7) + 1;
    localparam int unsigned NCLR = (BWD > IWD) ? BWD : IWD;
    localparam int unsigned CLW  = (NCLR > 1) ? $clog2(NCLR) : 1;

    // map memories
    logic [63:0]    bmem [BWD];
    logic [63:0]    imem [IWD];
    logic           bwe, iwe;
    logic [BAW-1:0] bwa, bra;
    logic [IAW-1:0] iwa, ira;
    logic [63:0]    bwd, brd, iwd, ird;

    always_ff @(posedge clk)
    begin
        if (bwe)
        begin
            bmem[bwa] <= bwd;
        end
        brd <= bmem[bra];
    end

    always_ff @(posedge clk)
    begin
        if (iwe)
        begin
            imem[iwa] <= iwd;
        end
        ird <= imem[ira];
    end

    // registers
    bbia_pkg::state_t state_reg, state_next;
    logic [CLW-1:0]   clr_reg, clr_next;
    logic [GW-1:0]    cnt_reg, cnt_next;
    logic [SW-1:0]    got_reg, got_next;
    logic [BAW-1:0]   bword_reg, bword_next;
    logic [BAW-1:0]   start_reg, start_next;
    logic             found_reg, found_next;
    logic [IAW-1:0]   iword_reg, iword_next;
    logic [63:0]      work_reg, work_next;
    logic [63:0]      free_reg, free_next;
    logic [16:0]      idx_reg, idx_next;
    bbia_pkg::out_t   pend_reg, pend_next;

    // effective limits
    logic [CBW-1:0] bc, res_lo, idx_b, bbase;
    logic [CIW-1:0] ic, idx_i, ibase;
    logic [BAW-1:0] blast;
    logic [IAW-1:0] ilast;
    logic [GW-1:0]  cnt_in;
    logic           accept;

    assign bc     = (CBW'(block_count) > CBW'(MAX_BLOCKS)) ? CBW'(MAX_BLOCKS)
                                                          : CBW'(block_count);
    assign ic     = (CIW'(inode_count) > CIW'(MAX_INODES)) ? CIW'(MAX_INODES)
                                                          : CIW'(inode_count);
    assign res_lo = CBW'(reserved_blocks);
    assign blast  = BAW'((bc - CBW'(1)) >> 6);
    assign ilast  = IAW'((ic - CIW'(1)) >> 6);
    assign idx_b  = CBW'(in_data.index);
    assign idx_i  = CIW'(in_data.index);
    assign cnt_in = (7'(in_data.count) > 7'(MAX_RUN)) ? GW'(MAX_RUN) : GW'(in_data.count);
    assign bbase  = CBW'({bword_reg, 6'd0});
    assign ibase  = CIW'({iword_reg, 6'd0});
    assign accept = in_valid && in_ready;

    // word scans
    logic [63:0]          bfree, ifree;
    bbia_pkg::scan_info_t binfo, iinfo;

    bbia_scan #(.W(CBW)) u_bscan (
        .word (brd),
        .base (bbase),
        .lo   (res_lo),
        .hi   (bc),
        .free (bfree),
        .info (binfo)
    );

    bbia_scan #(.W(CIW)) u_iscan (
        .word (ird),
        .base (ibase),
        .lo   (CIW'(1)),
        .hi   (ic),
        .free (ifree),
        .info (iinfo)
    );

    // pick step of a block allocation
    logic [5:0]    pfirst;
    logic [63:0]   pone;
    logic [SW-1:0] got_inc;
    logic          plast;
    logic [SW-1:0] bsum;
    logic          enough;
    logic [63:0]   ione;
    logic [63:0]   fmask_b, fmask_i;

    assign pfirst  = bbia_pkg::first_set(free_reg);
    assign pone    = 64'd1 << pfirst;
    assign got_inc = got_reg + SW'(1);
    assign plast   = (got_inc == SW'(cnt_reg));
    assign bsum    = got_reg + SW'(binfo.pop);
    assign enough  = (bsum >= SW'(cnt_reg));
    // isolate the lowest free inode bit
    assign ione    = ifree & (~ifree + 64'd1);
    assign fmask_b = ~(64'd1 << idx_reg[5:0]);
    assign fmask_i = ~(64'd1 << idx_reg[5:0]);

    // next state and register updates
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        got_next   = got_reg;
        bword_next = bword_reg;
        start_next = start_reg;
        found_next = found_reg;
        iword_next = iword_reg;
        work_next  = work_reg;
        free_next  = free_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        case (state_reg)
            bbia_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + CLW'(1);
                if (clr_reg == CLW'(NCLR - 1))
                begin
                    state_next = bbia_pkg::S_IDLE;
                end
            end
            bbia_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = in_data.index;
                    cnt_next   = cnt_in;
                    got_next   = '0;
                    found_next = 1'b0;
                    bword_next = '0;
                    iword_next = '0;
                    pend_next  = '{result_index: 17'd0, status: bbia_pkg::ST_OK, last: 1'b1};
                    state_next = bbia_pkg::S_EMIT;
                    case (in_data.cmd)
                        bbia_pkg::CMD_ALLOC_BLOCK:
                        begin
                            if (in_data.count == 5'd0)
                            begin
                                state_next = bbia_pkg::S_EMIT;
                            end
                            else if (bc == '0)
                            begin
                                pend_next.status = bbia_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                state_next = bbia_pkg::S_BRD1;
                            end
                        end
                        bbia_pkg::CMD_FREE_BLOCK:
                        begin
                            if (in_data.index == 17'd0)
                            begin
                                state_next = bbia_pkg::S_EMIT;
                            end
                            else if (idx_b >= bc)
                            begin
                                pend_next.status = bbia_pkg::ST_RANGE;
                            end
                            else
                            begin
                                bword_next = idx_b[BAW+5:6];
                                state_next = bbia_pkg::S_FBRD;
                            end
                        end
                        bbia_pkg::CMD_ALLOC_INODE:
                        begin
                            if (ic <= CIW'(1))
                            begin
                                pend_next.status = bbia_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                state_next = bbia_pkg::S_IRD;
                            end
                        end
                        default:
                        begin
                            if (in_data.index == 17'd0)
                            begin
                                state_next = bbia_pkg::S_EMIT;
                            end
                            else if (idx_i >= ic)
                            begin
                                pend_next.status = bbia_pkg::ST_RANGE;
                            end
                            else
                            begin
                                iword_next = idx_i[IAW+5:6];
                                state_next = bbia_pkg::S_FIRD;
                            end
                        end
                    endcase
                end
            end
            bbia_pkg::S_BRD1:
            begin
                state_next = bbia_pkg::S_BEV1;
            end
            bbia_pkg::S_BEV1:
            begin
                // remember the first word with a free bit so pass two starts there
                if (!found_reg && binfo.any)
                begin
                    found_next = 1'b1;
                    start_next = bword_reg;
                end
                if (enough)
                begin
                    got_next   = '0;
                    bword_next = found_reg ? start_reg : bword_reg;
                    state_next = bbia_pkg::S_BRD2;
                end
                else if (bword_reg == blast)
                begin
                    pend_next.status = bbia_pkg::ST_NO_SPACE;
                    state_next       = bbia_pkg::S_EMIT;
                end
                else
                begin
                    got_next   = bsum;
                    bword_next = bword_reg + BAW'(1);
                    state_next = bbia_pkg::S_BRD1;
                end
            end
            bbia_pkg::S_BRD2:
            begin
                state_next = bbia_pkg::S_BEV2;
            end
            bbia_pkg::S_BEV2:
            begin
                work_next  = brd;
                free_next  = bfree;
                state_next = bbia_pkg::S_BPICK;
            end
            bbia_pkg::S_BPICK:
            begin
                if (free_reg == '0)
                begin
                    bword_next = bword_reg + BAW'(1);
                    state_next = bbia_pkg::S_BRD2;
                end
                else if (slot_free)
                begin
                    work_next = work_reg | pone;
                    free_next = free_reg & ~pone;
                    got_next  = got_inc;
                    if (plast)
                    begin
                        state_next = bbia_pkg::S_IDLE;
                    end
                end
            end
            bbia_pkg::S_FBRD:
            begin
                state_next = bbia_pkg::S_FBWR;
            end
            bbia_pkg::S_FBWR:
            begin
                state_next = bbia_pkg::S_EMIT;
            end
            bbia_pkg::S_IRD:
            begin
                state_next = bbia_pkg::S_IEV;
            end
            bbia_pkg::S_IEV:
            begin
                if (iinfo.any)
                begin
                    pend_next.result_index = 17'(CIW'({iword_reg, iinfo.first}));
                    state_next             = bbia_pkg::S_EMIT;
                end
                else if (iword_reg == ilast)
                begin
                    pend_next.status = bbia_pkg::ST_NO_SPACE;
                    state_next       = bbia_pkg::S_EMIT;
                end
                else
                begin
                    iword_next = iword_reg + IAW'(1);
                    state_next = bbia_pkg::S_IRD;
                end
            end
            bbia_pkg::S_FIRD:
            begin
                state_next = bbia_pkg::S_FIWR;
            end
            bbia_pkg::S_FIWR:
            begin
                state_next = bbia_pkg::S_EMIT;
            end
            bbia_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = bbia_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bbia_pkg::S_IDLE;
            end
        endcase
    end

    // outputs: memory controls, ready and result issue
    always_comb
    begin
        bwe      = 1'b0;
        bwa      = bword_reg;
        bwd      = work_reg;
        bra      = bword_reg;
        iwe      = 1'b0;
        iwa      = iword_reg;
        iwd      = ird;
        ira      = iword_reg;
        in_ready = 1'b0;
        emit     = '0;
        case (state_reg)
            bbia_pkg::S_CLEAR:
            begin
                bwe = ({1'b0, clr_reg} < (CLW + 1)'(BWD));
                bwa = clr_reg[BAW-1:0];
                bwd = '0;
                iwe = ({1'b0, clr_reg} < (CLW + 1)'(IWD));
                iwa = clr_reg[IAW-1:0];
                iwd = '0;
            end
            bbia_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            bbia_pkg::S_BPICK:
            begin
                if (free_reg == '0)
                begin
                    bwe = 1'b1;
                end
                else if (slot_free)
                begin
                    emit.fire             = 1'b1;
                    emit.res.result_index = 17'(CBW'({bword_reg, pfirst}));
                    emit.res.status       = bbia_pkg::ST_OK;
                    emit.res.last         = plast;
                    // final result: store the word with this bit taken
                    bwe = plast;
                    bwd = work_reg | pone;
                end
            end
            bbia_pkg::S_FBWR:
            begin
                bwe = 1'b1;
                bwd = brd & fmask_b;
            end
            bbia_pkg::S_IEV:
            begin
                iwe = iinfo.any;
                iwd = ird | ione;
            end
            bbia_pkg::S_FIWR:
            begin
                iwe = 1'b1;
                iwd = ird & fmask_i;
            end
            bbia_pkg::S_EMIT:
            begin
                emit.fire = slot_free;
                emit.res  = pend_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbia_pkg::S_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            got_reg   <= '0;
            bword_reg <= '0;
            start_reg <= '0;
            found_reg <= 1'b0;
            iword_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            got_reg   <= got_next;
            bword_reg <= bword_next;
            start_reg <= start_next;
            found_reg <= found_next;
            iword_reg <= iword_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        free_reg <= free_next;
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
    end

    `BBIA_ASSERT_IMP(a_emit_slot, emit.fire, slot_free, "result issued into a full output register")
    `BBIA_ASSERT_NXT(a_last_idle, emit.fire && emit.res.last, state_reg == bbia_pkg::S_IDLE, "request not closed after last result")
    `BBIA_ASSERT_IMP(a_pick_bound, state_reg == bbia_pkg::S_BPICK, got_reg < SW'(cnt_reg), "more blocks issued than requested")
    `BBIA_ASSERT_IMP(a_idle_nowrite, state_reg == bbia_pkg::S_IDLE, !(bwe || iwe), "map write while idle")

endmodule

/* hw/rtl/bitmap_block_inode_allocator_top.sv */
// ----------------------------------------------------------------------------
// bitmap_block_inode_allocator_top
// First-fit block and inode allocator over two word-wide free maps.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   in        in_valid/in_ready    in_data  (cmd, count, index)
//   out       out_valid/out_ready  out_data (result_index, status, last)
//   cfg       cfg_we               cfg_index, cfg_data
//
// A free of a nonzero in-range index steps through accept, word read, write-back
// and result issue. Inode allocation reads and checks 64-bit map words in turn.
// Block allocation first reads words to count free bits, then rereads from the
// first free word and picks the blocks one by one.
// After reset a clearing pass zeroes both maps first. A full output register
// stalls issue; requests wait for the last result.
// ----------------------------------------------------------------------------
module bitmap_block_inode_allocator_top #(
    parameter int unsigned MAX_BLOCKS = bbia_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned MAX_INODES = bbia_pkg::MAX_INODES_DEF,
    parameter int unsigned MAX_RUN    = bbia_pkg::MAX_RUN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bbia_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output bbia_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [17:0]     cfg_data
);

    logic [17:0]     block_count_reg;
    logic [13:0]     inode_count_reg;
    logic [17:0]     reserved_reg;
    logic            out_valid_reg, out_valid_next;
    bbia_pkg::out_t  out_data_reg, out_data_next;
    logic            slot_free;
    bbia_pkg::emit_t emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= bbia_pkg::BLOCK_COUNT_RST;
            inode_count_reg <= bbia_pkg::INODE_COUNT_RST;
            reserved_reg    <= bbia_pkg::RESERVED_BLOCKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbia_pkg::CFG_BLOCK_COUNT:     block_count_reg <= cfg_data;
                bbia_pkg::CFG_INODE_COUNT:     inode_count_reg <= cfg_data[13:0];
                bbia_pkg::CFG_RESERVED_BLOCKS: reserved_reg    <= cfg_data;
                default:                       reserved_reg    <= reserved_reg;
            endcase
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    bbia_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_INODES (MAX_INODES),
        .MAX_RUN    (MAX_RUN)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .block_count     (block_count_reg),
        .inode_count     (inode_count_reg),
        .reserved_blocks (reserved_reg),
        .in_valid        (in_valid),
        .in_data         (in_data),
        .in_ready        (in_ready),
        .slot_free       (slot_free),
        .emit            (emit)
    );

    // output register: load on issue, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit.fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit.res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free-map allocator testbench
// Drives block and inode allocate/free requests through the valid/ready
// request channel and predicts every result from a bit-level copy of both
// free maps. Results are matched in order, field by field, under random
// gaps, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned NBLK      = 131072;
    localparam int unsigned NINO      = 8192;
    localparam int unsigned RUN_MAX   = 16;
    localparam int unsigned CYCLE_CAP = 3000000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    bbia_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    bbia_pkg::out_t out_data;
    logic           cfg_we;
    logic [1:0]     cfg_index;
    logic [17:0]    cfg_data;

    // predictor state
    bit          blk_used [NBLK];
    bit          ino_used [NINO];
    int unsigned num_blocks;
    int unsigned num_inodes;
    int unsigned num_reserved;
    int unsigned owned_blocks[$];
    int unsigned owned_inodes[$];

    bbia_pkg::out_t pending_results[$];
    int             mismatches;
    int             cycles;
    bit             jitter_on;
    int             hold_off_left;

    bitmap_block_inode_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_result(int unsigned idx, logic [1:0] st, logic lst);
        bbia_pkg::out_t r;
        r.result_index = idx[16:0];
        r.status       = st;
        r.last         = lst;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void predict_request(bbia_pkg::in_t r);
        int unsigned found[RUN_MAX];
        int unsigned want;
        int unsigned got;
        int unsigned eb;
        int unsigned ei;
        int unsigned idx;
        bit          done;
        eb   = (num_blocks > NBLK) ? NBLK : num_blocks;
        ei   = (num_inodes > NINO) ? NINO : num_inodes;
        idx  = r.index;
        got  = 0;
        done = 1'b0;
        case (r.cmd)
            bbia_pkg::CMD_ALLOC_BLOCK:
            begin
                want = (r.count > RUN_MAX) ? RUN_MAX : r.count;
                if (want == 0)
                begin
                    push_result(0, bbia_pkg::ST_OK, 1'b1);
                end
                else
                begin
                    for (int unsigned i = 0; i < eb && got < want; i++)
                    begin
                        if (i >= num_reserved && !blk_used[i])
                        begin
                            found[got] = i;
                            got++;
                        end
                    end
                    if (got < want)
                    begin
                        push_result(0, bbia_pkg::ST_NO_SPACE, 1'b1);
                    end
                    else
                    begin
                        for (int unsigned k = 0; k < want; k++)
                        begin
                            blk_used[found[k]] = 1'b1;
                            owned_blocks.insert(owned_blocks.size(), found[k]);
                            push_result(found[k], bbia_pkg::ST_OK, k + 1 == want);
                        end
                    end
                end
            end
            bbia_pkg::CMD_FREE_BLOCK:
            begin
                if (idx == 0)
                begin
                    push_result(0, bbia_pkg::ST_OK, 1'b1);
                end
                else if (idx >= eb)
                begin
                    push_result(0, bbia_pkg::ST_RANGE, 1'b1);
                end
                else
                begin
                    blk_used[idx] = 1'b0;
                    push_result(0, bbia_pkg::ST_OK, 1'b1);
                end
            end
            bbia_pkg::CMD_ALLOC_INODE:
            begin
                for (int unsigned i = 1; i < ei && !done; i++)
                begin
                    if (!ino_used[i])
                    begin
                        ino_used[i] = 1'b1;
                        owned_inodes.insert(owned_inodes.size(), i);
                        push_result(i, bbia_pkg::ST_OK, 1'b1);
                        done = 1'b1;
                    end
                end
                if (!done)
                begin
                    push_result(0, bbia_pkg::ST_NO_SPACE, 1'b1);
                end
            end
            default:
            begin
                if (idx == 0)
                begin
                    push_result(0, bbia_pkg::ST_OK, 1'b1);
                end
                else if (idx >= ei)
                begin
                    push_result(0, bbia_pkg::ST_RANGE, 1'b1);
                end
                else
                begin
                    ino_used[idx] = 1'b0;
                    push_result(0, bbia_pkg::ST_OK, 1'b1);
                end
            end
        endcase
    endfunction

    // hold valid until accepted; never drop and raise valid in one step
    task automatic send_request(bbia_pkg::in_t r);
        if (jitter_on && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 30)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_request(r);
    endtask

    task automatic send_cmd(logic [1:0] c, logic [4:0] n, logic [16:0] idx);
        bbia_pkg::in_t r;
        r.cmd   = c;
        r.count = n;
        r.index = idx;
        send_request(r);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(int unsigned blocks, int unsigned inodes, int unsigned rsv);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= bbia_pkg::CFG_BLOCK_COUNT;
        cfg_data  <= blocks[17:0];
        @(posedge clk);
        cfg_index <= bbia_pkg::CFG_INODE_COUNT;
        cfg_data  <= {4'd0, inodes[13:0]};
        @(posedge clk);
        cfg_index <= bbia_pkg::CFG_RESERVED_BLOCKS;
        cfg_data  <= rsv[17:0];
        @(posedge clk);
        cfg_we     <= 1'b0;
        num_blocks   = blocks & 18'h3FFFF;
        num_inodes   = inodes & 14'h3FFF;
        num_reserved = rsv & 18'h3FFFF;
        owned_blocks.delete();
    endtask

    task automatic test_reset_values;
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd0, 17'd0);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd1, 17'h1FFFF);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd31, 17'd0);
        send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'd0, 17'd0);
        send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'd0, 17'd2063);
        send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'd0, 17'h1FFFF);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd17, 17'd0);
        send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'd0, 17'd0);
        send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'd0, 17'd0);
        send_cmd(bbia_pkg::CMD_FREE_INODE, 5'd0, 17'd0);
        send_cmd(bbia_pkg::CMD_FREE_INODE, 5'd0, 17'd1);
        send_cmd(bbia_pkg::CMD_FREE_INODE, 5'd0, 17'd8191);
        send_cmd(bbia_pkg::CMD_FREE_INODE, 5'd0, 17'h1FFFF);
        send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'd0, 17'd0);
    endtask

    task automatic test_map_limits;
        // single block, nothing reserved: block zero is allocatable once
        set_config(1, 1, 0);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd1, 17'd0);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd1, 17'd0);
        send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'd0, 17'd0);
        send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'd0, 17'd1);
        send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'd0, 17'd0);
        // oversized counts clamp; everything reserved
        set_config(18'h3FFFF, 14'h3FFF, 18'h3FFFF);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd2, 17'd0);
        send_cmd(bbia_pkg::CMD_FREE_INODE, 5'd0, 17'd8191);
        send_cmd(bbia_pkg::CMD_FREE_INODE, 5'd0, 17'd8192);
        send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'd0, 17'd0);
        // top block of the map
        set_config(131072, 3, 131071);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd1, 17'd0);
        send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'd0, 17'h1FFFF);
        send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'd0, 17'd0);
        send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'd0, 17'd0);
        send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'd0, 17'd0);
        // freeing a reserved block clears its bit, but it is still never allocated
        set_config(96, 8, 0);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd16, 17'd0);
        set_config(96, 8, 8);
        send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'd0, 17'd3);
        send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, 5'd3, 17'd0);
    endtask

    task automatic random_request;
        int unsigned sel;
        int unsigned pos;
        logic [4:0]  n;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            n = 5'($urandom_range(1, 16));
            if ($urandom_range(9) == 0)
            begin
                n = 5'($urandom_range(31));
            end
            send_cmd(bbia_pkg::CMD_ALLOC_BLOCK, n, 17'($urandom));
        end
        else if (sel < 65 && owned_blocks.size() != 0)
        begin
            pos = $urandom_range(owned_blocks.size() - 1);
            send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'($urandom), owned_blocks[pos][16:0]);
            owned_blocks.delete(pos);
        end
        else if (sel < 75)
        begin
            send_cmd(bbia_pkg::CMD_FREE_BLOCK, 5'($urandom), 17'($urandom));
        end
        else if (sel < 90)
        begin
            send_cmd(bbia_pkg::CMD_ALLOC_INODE, 5'($urandom), 17'($urandom));
        end
        else if (owned_inodes.size() != 0 && sel < 96)
        begin
            pos = $urandom_range(owned_inodes.size() - 1);
            send_cmd(bbia_pkg::CMD_FREE_INODE, 5'($urandom), owned_inodes[pos][16:0]);
            owned_inodes.delete(pos);
        end
        else
        begin
            send_cmd(bbia_pkg::CMD_FREE_INODE, 5'($urandom),
                     17'($urandom_range(NINO + 200)));
        end
    endtask

    task automatic test_random_traffic;
        for (int p = 0; p < 4; p++)
        begin
            set_config($urandom_range(64, 700), $urandom_range(2, 200),
                       $urandom_range(0, 40));
            owned_inodes.delete();
            jitter_on = (p != 1);
            repeat (75) random_request();
        end
        jitter_on = 1'b1;
    endtask

    task automatic test_output_hold_off;
        drain();
        hold_off_left <= 400;
        jitter_on     = 1'b0;
        repeat (20) random_request();
        jitter_on = 1'b1;
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
        begin
            out_ready <= !jitter_on || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        bbia_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: index %0d status %0d last %0d",
                       out_data.result_index, out_data.status, out_data.last);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.result_index !== want.result_index)
                begin
                    $error("result_index: expected %0d, actual %0d",
                           want.result_index, out_data.result_index);
                    mismatches++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_data.status);
                    mismatches++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, out_data.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = bbia_pkg::CFG_BLOCK_COUNT;
        cfg_data      = '0;
        mismatches    = 0;
        cycles        = 0;
        jitter_on     = 1'b1;
        hold_off_left = 0;
        num_blocks    = bbia_pkg::BLOCK_COUNT_RST;
        num_inodes    = bbia_pkg::INODE_COUNT_RST;
        num_reserved  = bbia_pkg::RESERVED_BLOCKS_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_map_limits();
        test_random_traffic();
        test_output_hold_off();
        drain();
        repeat (100) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
